// ===== design/mvn_pkg.sv =====
`timescale 1ns / 1ps

package mvn_pkg;

    localparam int VertexCount = 1024;
    localparam int IdxW        = 10;
    localparam int CoordW      = 16;
    localparam int SumW        = 24;
    localparam int NormW       = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [SumW-1:0] SUM_MAX = 24'sd8388607;
    localparam logic signed [SumW-1:0] SUM_MIN = -24'sd8388608;

    // request to the normalising unit
    typedef struct packed {
        logic               start;
        logic signed [40:0] vx;
        logic signed [40:0] vy;
        logic signed [40:0] vz;
    } norm_req_t;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic signed [NormW-1:0] nx;
        logic signed [NormW-1:0] ny;
        logic signed [NormW-1:0] nz;
    } norm_rsp_t;

    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0]  acc,
        input logic signed [NormW-1:0] d
    );
        logic signed [SumW:0] r;
        r = {acc[SumW-1], acc} + {{(SumW+1-NormW){d[NormW-1]}}, d};
        if (r > $signed({SUM_MAX[SumW-1], SUM_MAX})) return SUM_MAX;
        if (r < $signed({SUM_MIN[SumW-1], SUM_MIN})) return SUM_MIN;
        return r[SumW-1:0];
    endfunction

endpackage

// ===== design/mesh_vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps

// Mesh vertex normal accumulator.
// Input channel s_*: op load (0) stores a vertex position and clears its
// normal sum; op triangle (1) reads corners a,b,c, forms (b-a)x(c-a),
// normalises it to Q2.14 and adds it, saturating, to all three sums;
// op read (2) normalises the sum of vertex_index and returns it on m_*.
// One transaction at a time. A load or an unused op is taken without
// leaving the idle state. A triangle reads the three positions, forms the
// cross product, normalises it and then does three read-modify-writes of
// the sums. A degenerate triangle, or a read of a zero sum, skips the
// square root and divides. The next transaction can be taken in the cycle
// that a read's result becomes valid. The normaliser uses a bit-serial
// square root and three restoring divides. Positions and sums sit in two
// memories with registered reads.
// A result waits in the output register while m_ready is low; the next
// transaction is taken meanwhile unless it is itself a read.
// Reset clears control state only; memories hold garbage until loaded.
module mesh_vertex_normal_accumulator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [9:0]          s_vertex_index,
    input  logic signed [15:0]  s_coord_x,
    input  logic signed [15:0]  s_coord_y,
    input  logic signed [15:0]  s_coord_z,
    input  logic [9:0]          s_corner_a,
    input  logic [9:0]          s_corner_b,
    input  logic [9:0]          s_corner_c,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_normal_x,
    output logic signed [15:0]  m_normal_y,
    output logic signed [15:0]  m_normal_z,
    output logic [9:0]          m_normal_vertex,
    output logic                m_zero_length
);

    typedef enum logic [3:0] {
        S_IDLE, S_PRD, S_PWAIT, S_NREQ, S_NWAIT, S_ARD, S_AWR, S_RRD, S_RWAIT
    } state_t;

    logic [47:0]                   pos_mem [mvn_pkg::VertexCount];
    logic [3*mvn_pkg::SumW-1:0]    sum_mem [mvn_pkg::VertexCount];
    logic [47:0]                   pos_q;
    logic [3*mvn_pkg::SumW-1:0]    sum_q;

    state_t             state_reg;
    logic [9:0]         idx_reg [3];
    logic [1:0]         k_reg;
    logic signed [16:0] pa_reg [3];
    logic signed [16:0] u_reg [3];
    logic signed [16:0] w_reg [3];
    logic               isread_reg;
    logic [9:0]         vi_reg;
    logic signed [15:0] n_reg [3];
    mvn_pkg::norm_req_t req;
    mvn_pkg::norm_rsp_t rsp;
    logic [9:0]         raddr;
    logic               busy;
    logic signed [16:0] px, py, pz;
    logic signed [40:0] cx, cy, cz;

    mvn_norm u_norm (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    assign busy    = state_reg != S_IDLE;
    assign s_ready = !busy && !(m_valid && s_op == mvn_pkg::OP_READ);
    assign px = 17'(signed'(pos_q[15:0]));
    assign py = 17'(signed'(pos_q[31:16]));
    assign pz = 17'(signed'(pos_q[47:32]));

    always_comb begin
        cx = 41'(u_reg[1] * w_reg[2]) - 41'(u_reg[2] * w_reg[1]);
        cy = 41'(u_reg[2] * w_reg[0]) - 41'(u_reg[0] * w_reg[2]);
        cz = 41'(u_reg[0] * w_reg[1]) - 41'(u_reg[1] * w_reg[0]);
        raddr = idx_reg[k_reg];
        if (state_reg == S_RRD) raddr = vi_reg;
    end

    always_ff @(posedge aclk) begin
        pos_q <= pos_mem[raddr];
        sum_q <= sum_mem[raddr];
        if (state_reg == S_IDLE && s_valid && s_ready && s_op == mvn_pkg::OP_LOAD) begin
            pos_mem[s_vertex_index] <= {s_coord_z, s_coord_y, s_coord_x};
            sum_mem[s_vertex_index] <= '0;
        end else if (state_reg == S_AWR) begin
            sum_mem[idx_reg[k_reg]] <= {
                mvn_pkg::sat_add(sum_q[71:48], n_reg[2]),
                mvn_pkg::sat_add(sum_q[47:24], n_reg[1]),
                mvn_pkg::sat_add(sum_q[23:0],  n_reg[0])};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            req.start <= 1'b0;
        end else begin
            req.start <= (state_reg == S_NREQ) || (state_reg == S_RWAIT);
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        idx_reg[0] <= s_corner_a;
                        idx_reg[1] <= s_corner_b;
                        idx_reg[2] <= s_corner_c;
                        vi_reg <= s_vertex_index;
                        k_reg  <= 2'd0;
                        if (s_op == mvn_pkg::OP_TRI) state_reg <= S_PRD;
                        else if (s_op == mvn_pkg::OP_READ) state_reg <= S_RRD;
                    end
                end
                S_PRD: state_reg <= S_PWAIT;
                S_PWAIT: begin
                    if (k_reg == 2'd0) begin
                        pa_reg[0] <= px; pa_reg[1] <= py; pa_reg[2] <= pz;
                    end else if (k_reg == 2'd1) begin
                        u_reg[0] <= px - pa_reg[0];
                        u_reg[1] <= py - pa_reg[1];
                        u_reg[2] <= pz - pa_reg[2];
                    end else begin
                        w_reg[0] <= px - pa_reg[0];
                        w_reg[1] <= py - pa_reg[1];
                        w_reg[2] <= pz - pa_reg[2];
                    end
                    if (k_reg == 2'd2) state_reg <= S_NREQ;
                    else begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_PRD;
                    end
                end
                S_NREQ: begin
                    req.vx <= cx; req.vy <= cy; req.vz <= cz;
                    isread_reg <= 1'b0;
                    state_reg <= S_NWAIT;
                end
                S_RRD: state_reg <= S_RWAIT;
                S_RWAIT: begin
                    req.vx <= 41'(signed'(sum_q[23:0]));
                    req.vy <= 41'(signed'(sum_q[47:24]));
                    req.vz <= 41'(signed'(sum_q[71:48]));
                    isread_reg <= 1'b1;
                    state_reg <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (rsp.done) begin
                        if (isread_reg) begin
                            m_valid <= 1'b1;
                            m_normal_x <= rsp.nx;
                            m_normal_y <= rsp.ny;
                            m_normal_z <= rsp.nz;
                            m_zero_length <= rsp.zero;
                            m_normal_vertex <= vi_reg;
                            state_reg <= S_IDLE;
                        end else begin
                            n_reg[0] <= rsp.nx; n_reg[1] <= rsp.ny; n_reg[2] <= rsp.nz;
                            k_reg <= 2'd0;
                            state_reg <= S_ARD;
                        end
                    end
                end
                S_ARD: state_reg <= S_AWR;
                S_AWR: begin
                    if (k_reg == 2'd2) state_reg <= S_IDLE;
                    else begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_ARD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/mvn_norm.sv =====
`timescale 1ns / 1ps

// Multi-cycle vector normaliser: align, square-sum, bit-serial sqrt,
// then three restoring divides one bit a cycle.
module mvn_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  mvn_pkg::norm_req_t req,
    output mvn_pkg::norm_rsp_t rsp
);

    typedef enum logic [3:0] {
        N_IDLE, N_SHR, N_SHL, N_SQ0, N_SQ1, N_SQ2, N_SQRT, N_DIV, N_DONE
    } nstate_t;

    nstate_t            state_reg;
    logic [40:0]        m_reg [3];
    logic [2:0]         neg_reg;
    logic [61:0]        s_reg;
    logic [61:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic [44:0]        num_reg;
    logic [44:0]        dsh_reg;
    logic [15:0]        quo_reg;
    logic [15:0]        q_reg [3];
    logic [40:0]        mx;
    logic [59:0]        sq;
    logic [63:0]        trial;
    logic [63:0]        rem_sh;
    logic               dge;

    always_comb begin
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
        sq = m_reg[comp_reg][29:0] * m_reg[comp_reg][29:0];
        rem_sh = {rem_reg, s_reg[61:60]};
        trial = {30'd0, root_reg, 2'b01};
        dge = num_reg >= dsh_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            rsp.done  <= 1'b0;
        end else begin
            rsp.done <= (state_reg == N_DONE);
            unique case (state_reg)
                N_IDLE: begin
                    if (req.start) begin
                        m_reg[0] <= req.vx[40] ? 41'(-req.vx) : req.vx;
                        m_reg[1] <= req.vy[40] ? 41'(-req.vy) : req.vy;
                        m_reg[2] <= req.vz[40] ? 41'(-req.vz) : req.vz;
                        neg_reg  <= {req.vz[40], req.vy[40], req.vx[40]};
                        state_reg <= N_SHR;
                    end
                end
                N_SHR: begin
                    if (mx == '0) begin
                        rsp.zero <= 1'b1;
                        rsp.nx <= '0;
                        rsp.ny <= '0;
                        rsp.nz <= '0;
                        state_reg <= N_DONE;
                    end else if (mx >= 41'd1 << 30) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    end else begin
                        state_reg <= N_SHL;
                    end
                end
                N_SHL: begin
                    if (mx < 41'd1 << 29) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    end else begin
                        s_reg    <= '0;
                        comp_reg <= 2'd0;
                        state_reg <= N_SQ0;
                    end
                end
                N_SQ0, N_SQ1, N_SQ2: begin
                    s_reg <= s_reg + 62'(sq);
                    if (comp_reg == 2'd2) begin
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= 6'd30;
                        state_reg <= N_SQRT;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                N_SQRT: begin
                    // two radicand bits consumed, one root bit per cycle
                    s_reg <= s_reg << 2;
                    if (rem_sh >= trial) begin
                        rem_reg  <= 62'(rem_sh - trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        rem_reg  <= 62'(rem_sh);
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == '0) begin
                        comp_reg <= 2'd0;
                        state_reg <= N_DIV;
                        cnt_reg  <= 6'd0;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                N_DIV: begin
                    if (cnt_reg == 6'd0) begin
                        dsh_reg  <= {root_reg[30:0], 14'd0};
                        num_reg  <= {1'b0, m_reg[comp_reg][29:0], 14'd0}
                                    + 45'(root_reg >> 1);
                        quo_reg  <= '0;
                        cnt_reg  <= 6'd1;
                    end else begin
                        // quotient < 2^15: divisor starts at d<<14, walks right
                        if (dge) num_reg <= num_reg - dsh_reg;
                        quo_reg <= {quo_reg[14:0], dge};
                        dsh_reg <= dsh_reg >> 1;
                        if (cnt_reg == 6'd15) begin
                            cnt_reg <= 6'd0;
                            q_reg[comp_reg] <= {quo_reg[14:0], dge};
                            if (comp_reg == 2'd2) state_reg <= N_DONE;
                            else comp_reg <= comp_reg + 2'd1;
                        end else begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                end
                N_DONE: begin
                    state_reg <= N_IDLE;
                end
                default: state_reg <= N_IDLE;
            endcase
            if (state_reg == N_SHL) rsp.zero <= 1'b0;
            if (state_reg == N_DONE && !rsp.zero) begin
                rsp.nx <= neg_reg[0] ? -$signed(q_reg[0]) : $signed(q_reg[0]);
                rsp.ny <= neg_reg[1] ? -$signed(q_reg[1]) : $signed(q_reg[1]);
                rsp.nz <= neg_reg[2] ? -$signed(q_reg[2]) : $signed(q_reg[2]);
            end
        end
    end

endmodule

// ===== tb/tb_mesh_vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps

module tb_mesh_vertex_normal_accumulator;

    typedef struct {
        logic [1:0]         op;
        logic [9:0]         vi;
        logic signed [15:0] cx, cy, cz;
        logic [9:0]         ca, cb, cc;
        bit                 drain;
    } mesh_op_t;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic [9:0]         vtx;
        logic               zero;
    } normal_t;

    localparam int CycleLimit = 2000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_op = mvn_pkg::OP_LOAD;
    logic [9:0] s_vertex_index = '0;
    logic signed [15:0] s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    logic [9:0] s_corner_a = '0, s_corner_b = '0, s_corner_c = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_normal_x, m_normal_y, m_normal_z;
    logic [9:0] m_normal_vertex;
    logic m_zero_length;

    mesh_vertex_normal_accumulator uut (.*);

    always #5 aclk = ~aclk;

    mesh_op_t pending_ops[$];
    normal_t  expected_normals[$];
    int errors = 0;
    int ops_sent = 0;
    int ops_total = 0;
    int normals_seen = 0;
    longint cycle_count = 0;

    // shadow of the block's memories
    logic signed [15:0] pos_x[mvn_pkg::VertexCount], pos_y[mvn_pkg::VertexCount],
                        pos_z[mvn_pkg::VertexCount];
    logic signed [23:0] acc_x[mvn_pkg::VertexCount], acc_y[mvn_pkg::VertexCount],
                        acc_z[mvn_pkg::VertexCount];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // returns 1 for a zero vector
    function automatic bit normalise(input longint v[3], output logic signed [15:0] n[3]);
        longint unsigned m[3];
        longint unsigned mx, s, len, q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
            n[i] = '0;
        end
        if (mx == 0) return 1;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            n[i] = v[i] < 0 ? -q[15:0] : q[15:0];
        end
        return 0;
    endfunction

    function automatic logic signed [23:0] clamp_add(logic signed [23:0] a,
                                                     logic signed [15:0] d);
        longint r;
        r = longint'(a) + longint'(d);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    task automatic accumulate_op(mesh_op_t it);
        longint u[3], w[3], cr[3];
        logic signed [15:0] n[3];
        normal_t e;
        bit z;
        logic [9:0] k[3];
        case (it.op)
            mvn_pkg::OP_LOAD: begin
                pos_x[it.vi] = it.cx;
                pos_y[it.vi] = it.cy;
                pos_z[it.vi] = it.cz;
                acc_x[it.vi] = '0;
                acc_y[it.vi] = '0;
                acc_z[it.vi] = '0;
            end
            mvn_pkg::OP_TRI: begin
                u[0] = longint'(pos_x[it.cb]) - pos_x[it.ca];
                u[1] = longint'(pos_y[it.cb]) - pos_y[it.ca];
                u[2] = longint'(pos_z[it.cb]) - pos_z[it.ca];
                w[0] = longint'(pos_x[it.cc]) - pos_x[it.ca];
                w[1] = longint'(pos_y[it.cc]) - pos_y[it.ca];
                w[2] = longint'(pos_z[it.cc]) - pos_z[it.ca];
                cr[0] = u[1] * w[2] - u[2] * w[1];
                cr[1] = u[2] * w[0] - u[0] * w[2];
                cr[2] = u[0] * w[1] - u[1] * w[0];
                z = normalise(cr, n);
                k[0] = it.ca; k[1] = it.cb; k[2] = it.cc;
                for (int i = 0; i < 3; i++) begin
                    acc_x[k[i]] = clamp_add(acc_x[k[i]], n[0]);
                    acc_y[k[i]] = clamp_add(acc_y[k[i]], n[1]);
                    acc_z[k[i]] = clamp_add(acc_z[k[i]], n[2]);
                end
            end
            mvn_pkg::OP_READ: begin
                u[0] = acc_x[it.vi];
                u[1] = acc_y[it.vi];
                u[2] = acc_z[it.vi];
                e.zero = normalise(u, n);
                e.nx = n[0]; e.ny = n[1]; e.nz = n[2];
                e.vtx = it.vi;
                expected_normals.push_back(e);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(20, 4);
        return $urandom_range(150, 50);
    endfunction

    // driver
    int send_gap = 0;
    bit holding;
    always @(posedge aclk) begin
        mesh_op_t it;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                it.op = s_op; it.vi = s_vertex_index;
                it.cx = s_coord_x; it.cy = s_coord_y; it.cz = s_coord_z;
                it.ca = s_corner_a; it.cb = s_corner_b; it.cc = s_corner_c;
                accumulate_op(it);
                ops_sent++;
            end
            holding = s_valid && !s_ready;
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 0;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].drain && expected_normals.size() != 0)) begin
                    it = pending_ops.pop_front();
                    s_op <= it.op; s_vertex_index <= it.vi;
                    s_coord_x <= it.cx; s_coord_y <= it.cy; s_coord_z <= it.cz;
                    s_corner_a <= it.ca; s_corner_b <= it.cb; s_corner_c <= it.cc;
                    s_valid <= 1;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    int ready_gap = 0;
    int hold_off = 0;
    bit held_once = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!held_once && normals_seen >= 30) begin
                held_once = 1;
                hold_off = 800;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                ready_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        normal_t e;
        if (aresetn && m_valid && m_ready) begin
            normals_seen++;
            if (expected_normals.size() == 0) begin
                $error("unexpected transaction for vertex %0d", m_normal_vertex);
                errors++;
            end else begin
                e = expected_normals.pop_front();
                if (m_normal_x !== e.nx) begin
                    $error("normal_x exp %0d got %0d", e.nx, m_normal_x); errors++;
                end
                if (m_normal_y !== e.ny) begin
                    $error("normal_y exp %0d got %0d", e.ny, m_normal_y); errors++;
                end
                if (m_normal_z !== e.nz) begin
                    $error("normal_z exp %0d got %0d", e.nz, m_normal_z); errors++;
                end
                if (m_normal_vertex !== e.vtx) begin
                    $error("normal_vertex exp %0d got %0d", e.vtx, m_normal_vertex);
                    errors++;
                end
                if (m_zero_length !== e.zero) begin
                    $error("zero_length exp %0d got %0d", e.zero, m_zero_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    bit loaded[mvn_pkg::VertexCount];
    int loaded_list[$];

    function automatic mesh_op_t mk(logic [1:0] op, int vi, int cx, int cy, int cz,
                                    int a, int b, int c);
        mesh_op_t it;
        it.op = op; it.vi = vi[9:0];
        it.cx = cx[15:0]; it.cy = cy[15:0]; it.cz = cz[15:0];
        it.ca = a[9:0]; it.cb = b[9:0]; it.cc = c[9:0];
        it.drain = 0;
        if (op == mvn_pkg::OP_LOAD && !loaded[vi]) begin
            loaded[vi] = 1;
            loaded_list.push_back(vi);
        end
        return it;
    endfunction

    task automatic queue_op(mesh_op_t it);
        pending_ops.push_back(it);
        ops_total++;
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    initial begin
        mesh_op_t it;
        int r, vi, a, b, c;
        // directed: extremes, degenerate and repeated corners, unused op
        queue_op(mk(mvn_pkg::OP_LOAD, 0, 32767, -32768, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 1, -32768, 32767, 32767, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 2, 0, 0, -32768, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 1023, -1, 1, -1, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 2));
        queue_op(mk(mvn_pkg::OP_TRI, 0, 0, 0, 0, 0, 0, 1));
        queue_op(mk(mvn_pkg::OP_TRI, 1023, -1, -1, -1, 0, 1, 1023));
        queue_op(mk(mvn_pkg::OP_TRI, 0, 0, 0, 0, 1023, 1023, 2));
        queue_op(mk(mvn_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 5, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 6, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 7, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_TRI, 0, 0, 0, 0, 5, 6, 7));
        queue_op(mk(mvn_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_SPARE, 1023, -1, -1, -1, 1023, 1023, 1023));
        it = mk(mvn_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0);
        it.drain = 1;
        queue_op(it);
        // one fixed triangle over and over: x sum runs to the floor, y to the ceiling
        queue_op(mk(mvn_pkg::OP_LOAD, 10, 0, 0, 0, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 11, 0, 0, 256, 0, 0, 0));
        queue_op(mk(mvn_pkg::OP_LOAD, 12, 256, 256, 0, 0, 0, 0));
        for (int i = 0; i < 730; i++) begin
            queue_op(mk(mvn_pkg::OP_TRI, 0, 0, 0, 0, 10, 11, 12));
            if (i % 100 == 99) queue_op(mk(mvn_pkg::OP_READ, 11, 0, 0, 0, 0, 0, 0));
        end
        queue_op(mk(mvn_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 290; i++) begin
            r = $urandom_range(99);
            if (r < 25) begin
                vi = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(31);
                if ($urandom_range(4) == 0)
                    it = mk(mvn_pkg::OP_LOAD, vi, $urandom_range(600) - 300,
                            $urandom_range(600) - 300, $urandom_range(600) - 300,
                            $urandom, $urandom, $urandom);
                else
                    it = mk(mvn_pkg::OP_LOAD, vi, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
            end else if (r < 65) begin
                a = any_loaded(); b = any_loaded(); c = any_loaded();
                if ($urandom_range(9) == 0) c = a;
                it = mk(mvn_pkg::OP_TRI, $urandom, $urandom, $urandom, $urandom, a, b, c);
            end else if (r < 95) begin
                it = mk(mvn_pkg::OP_READ, any_loaded(), $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
            end else begin
                it = mk(mvn_pkg::OP_SPARE, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
            end
            queue_op(it);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1;
        while (ops_sent < ops_total || expected_normals.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d transactions (loads, triangles, reads, unused op), checked %0d normals",
                 ops_sent, normals_seen);
        $display("including accumulator saturation, degenerate faces and a long output stall");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
